// ===== rtl/modular_field_alu_macros.svh =====
// Assertion helpers for the modular field ALU sources.
`ifndef MODULAR_FIELD_ALU_MACROS_SVH
`define MODULAR_FIELD_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modular_field_alu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modular_field_alu: next-cycle check failed");

`endif

// ===== rtl/mfa_pkg.sv =====
package mfa_pkg;

  localparam int QW          = 31;
  localparam int OPW         = 32;
  localparam int W           = QW + 3;
  localparam int CNT_W       = $clog2((OPW > QW) ? OPW : QW);
  localparam int K_W         = $clog2(QW + 1);
  localparam int IN_TDATA_W  = ((2 * OPW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((QW + 7) / 8) * 8;

  localparam logic [QW-1:0] MOD_RESET = QW'(64'd2147483647);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_INV = 2'd3;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    logic  sub;
  } unit_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [QW-1:0] value;
    logic          no_inverse;
  } result_t;

  function automatic word_t zext(input logic [QW:0] v);
    return signed'({{(W - QW - 1){1'b0}}, v});
  endfunction

endpackage

// ===== rtl/mfa_addsub.sv =====
module mfa_addsub (
  input  mfa_pkg::unit_req_t req,
  output mfa_pkg::word_t     sum
);
  import mfa_pkg::*;

  assign sum = req.x + (req.sub ? ~req.y : req.y) + word_t'(req.sub);

endmodule

// ===== rtl/mfa_core.sv =====
module mfa_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             op_in,
  input  logic [mfa_pkg::OPW-1:0] a_in,
  input  logic [mfa_pkg::OPW-1:0] b_in,
  input  logic [mfa_pkg::QW-1:0] modulus,
  input  logic                   out_free,
  output mfa_pkg::core_stat_t    stat,
  output mfa_pkg::result_t       res
);
  import mfa_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RED      = 4'd1;
  localparam logic [3:0] S_RED_END  = 4'd2;
  localparam logic [3:0] S_ADD      = 4'd3;
  localparam logic [3:0] S_FIXQ     = 4'd4;
  localparam logic [3:0] S_SUB      = 4'd5;
  localparam logic [3:0] S_SUB_FIX  = 4'd6;
  localparam logic [3:0] S_MUL_DBL  = 4'd7;
  localparam logic [3:0] S_MUL_ADD  = 4'd8;
  localparam logic [3:0] S_INV_TEST = 4'd9;
  localparam logic [3:0] S_INV_ALN  = 4'd10;
  localparam logic [3:0] S_INV_SUB  = 4'd11;
  localparam logic [3:0] S_INV_TSUB = 4'd12;
  localparam logic [3:0] S_INV_END  = 4'd13;
  localparam logic [3:0] S_INV_WRAP = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  function automatic logic [OPW-1:0] magnitude(input logic [OPW-1:0] v);
    return v[OPW-1] ? (~v + OPW'(1)) : v;
  endfunction

  logic [3:0]     state, state_next;
  logic [1:0]     op, op_next;
  logic           which, which_next;
  logic           neg, neg_next;
  logic [OPW-1:0] cur, cur_next;
  logic [OPW-1:0] bhold, bhold_next;
  word_t          acc, acc_next;
  logic [QW-1:0]  ra, ra_next;
  logic [QW-1:0]  rb, rb_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [QW-1:0]  r0, r0_next;
  logic [QW-1:0]  r1, r1_next;
  word_t          t0, t0_next;
  word_t          t1, t1_next;
  word_t          d, d_next;
  word_t          td, td_next;
  logic [K_W-1:0] k, k_next;
  result_t        res_next;

  unit_req_t      req;
  word_t          sum;

  mfa_addsub u_addsub (
    .req (req),
    .sum (sum)
  );

  always_comb begin
    logic [QW:0]   rem2;
    word_t         acc2;
    word_t         qw;
    word_t         fixed;
    logic [QW-1:0] resid;
    logic [QW-1:0] rcur;
    word_t         tcur;

    state_next = state;
    op_next    = op;
    which_next = which;
    neg_next   = neg;
    cur_next   = cur;
    bhold_next = bhold;
    acc_next   = acc;
    ra_next    = ra;
    rb_next    = rb;
    cnt_next   = cnt;
    r0_next    = r0;
    r1_next    = r1;
    t0_next    = t0;
    t1_next    = t1;
    d_next     = d;
    td_next    = td;
    k_next     = k;
    res_next   = res;
    req        = '{x: '0, y: '0, sub: 1'b0};

    rem2  = {acc[QW-1:0], cur[OPW-1]};
    acc2  = acc <<< 1;
    qw    = zext({1'b0, modulus});
    fixed = '0;
    resid = '0;
    rcur  = r0;
    tcur  = t0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = op_in;
          bhold_next = b_in;
          which_next = (op_in == OP_INV);
          cur_next   = (op_in == OP_INV) ? magnitude(b_in) : magnitude(a_in);
          neg_next   = (op_in == OP_INV) ? b_in[OPW-1] : a_in[OPW-1];
          acc_next   = '0;
          cnt_next   = '0;
          if (modulus < QW'(2)) begin
            res_next   = '{value: '0, no_inverse: (op_in == OP_INV)};
            state_next = S_DONE;
          end else begin
            state_next = S_RED;
          end
        end
      end

      // Restoring reduction of the operand magnitude, one bit per cycle.
      S_RED: begin
        req      = '{x: zext(rem2), y: qw, sub: 1'b1};
        acc_next = sum[W-1] ? zext(rem2) : sum;
        cur_next = cur << 1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(OPW - 1)) begin
          state_next = S_RED_END;
        end
      end

      S_RED_END: begin
        req   = '{x: qw, y: acc, sub: 1'b1};
        resid = (neg && (acc != '0)) ? sum[QW-1:0] : acc[QW-1:0];
        acc_next = '0;
        cnt_next = '0;
        if (!which) begin
          ra_next    = resid;
          which_next = 1'b1;
          cur_next   = magnitude(bhold);
          neg_next   = bhold[OPW-1];
          state_next = S_RED;
        end else begin
          rb_next = resid;
          case (op)
            OP_ADD:  state_next = S_ADD;
            OP_SUB:  state_next = S_SUB;
            OP_MUL:  state_next = S_MUL_DBL;
            default: begin
              r0_next    = modulus;
              r1_next    = resid;
              t0_next    = '0;
              t1_next    = word_t'(1);
              state_next = S_INV_TEST;
            end
          endcase
        end
      end

      S_ADD: begin
        req        = '{x: zext({1'b0, ra}), y: zext({1'b0, rb}), sub: 1'b0};
        acc_next   = sum;
        state_next = S_FIXQ;
      end

      S_FIXQ: begin
        req   = '{x: acc, y: qw, sub: 1'b1};
        fixed = sum[W-1] ? acc : sum;
        if (op == OP_ADD) begin
          res_next   = '{value: fixed[QW-1:0], no_inverse: 1'b0};
          state_next = S_DONE;
        end else begin
          acc_next = fixed;
          if (cnt == CNT_W'(QW - 1)) begin
            res_next   = '{value: fixed[QW-1:0], no_inverse: 1'b0};
            state_next = S_DONE;
          end else begin
            cnt_next   = cnt + CNT_W'(1);
            state_next = S_MUL_DBL;
          end
        end
      end

      S_SUB: begin
        req        = '{x: zext({1'b0, ra}), y: zext({1'b0, rb}), sub: 1'b1};
        acc_next   = sum;
        state_next = S_SUB_FIX;
      end

      S_SUB_FIX: begin
        req        = '{x: acc, y: qw, sub: 1'b0};
        fixed      = acc[W-1] ? sum : acc;
        res_next   = '{value: fixed[QW-1:0], no_inverse: 1'b0};
        state_next = S_DONE;
      end

      // Double and add, most significant multiplier bit first.
      S_MUL_DBL: begin
        req     = '{x: acc2, y: qw, sub: 1'b1};
        fixed   = sum[W-1] ? acc2 : sum;
        rb_next = rb << 1;
        acc_next = fixed;
        if (rb[QW-1]) begin
          state_next = S_MUL_ADD;
        end else if (cnt == CNT_W'(QW - 1)) begin
          res_next   = '{value: fixed[QW-1:0], no_inverse: 1'b0};
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      S_MUL_ADD: begin
        req        = '{x: acc, y: zext({1'b0, ra}), sub: 1'b0};
        acc_next   = sum;
        state_next = S_FIXQ;
      end

      S_INV_TEST: begin
        if (r1 == '0) begin
          state_next = S_INV_END;
        end else begin
          d_next     = zext({1'b0, r1});
          td_next    = t1;
          k_next     = '0;
          state_next = S_INV_ALN;
        end
      end

      // Shift the divisor up to the largest power-of-two multiple that fits.
      S_INV_ALN: begin
        req = '{x: zext({1'b0, r0}), y: d <<< 1, sub: 1'b1};
        if (!sum[W-1]) begin
          d_next  = d <<< 1;
          td_next = td <<< 1;
          k_next  = k + K_W'(1);
        end else begin
          state_next = S_INV_SUB;
        end
      end

      S_INV_SUB, S_INV_TSUB: begin
        if (state == S_INV_SUB) begin
          req = '{x: zext({1'b0, r0}), y: d, sub: 1'b1};
        end else begin
          req  = '{x: t0, y: td, sub: 1'b1};
          tcur = sum;
        end
        if ((state == S_INV_SUB) && !sum[W-1]) begin
          r0_next    = sum[QW-1:0];
          state_next = S_INV_TSUB;
        end else if (k == '0) begin
          r0_next    = r1;
          r1_next    = rcur;
          t0_next    = t1;
          t1_next    = tcur;
          state_next = S_INV_TEST;
        end else begin
          t0_next    = tcur;
          d_next     = d >>> 1;
          td_next    = td >>> 1;
          k_next     = k - K_W'(1);
          state_next = S_INV_SUB;
        end
      end

      S_INV_END: begin
        req = '{x: t0, y: qw, sub: 1'b0};
        if (r0 != QW'(1)) begin
          res_next   = '{value: '0, no_inverse: 1'b1};
          state_next = S_DONE;
        end else begin
          acc_next   = t0[W-1] ? sum : t0;
          state_next = S_INV_WRAP;
        end
      end

      S_INV_WRAP: begin
        req        = '{x: acc, y: qw, sub: 1'b1};
        fixed      = sum[W-1] ? acc : sum;
        res_next   = '{value: fixed[QW-1:0], no_inverse: 1'b0};
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    which <= which_next;
    neg   <= neg_next;
    cur   <= cur_next;
    bhold <= bhold_next;
    acc   <= acc_next;
    ra    <= ra_next;
    rb    <= rb_next;
    cnt   <= cnt_next;
    r0    <= r0_next;
    r1    <= r1_next;
    t0    <= t0_next;
    t1    <= t1_next;
    d     <= d_next;
    td    <= td_next;
    k     <= k_next;
    res   <= res_next;
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE) && out_free;

endmodule

// ===== rtl/modular_field_alu.sv =====
// Channel    Direction  Transaction contents
// cfg        in         modulus
// s_axis     in         opcode (tuser), operand_a and operand_b (tdata)
// m_axis     out        result (tdata), no_inverse (tuser)
//
// Each operand is reduced one bit per cycle by a single shared adder, then corrected for sign
// (the inverse reduces only operand_b). Add and subtract then add or subtract and correct by
// the modulus, multiply doubles and conditionally adds once per modulus bit, and inverse runs
// extended Euclid steps that align the divisor and subtract. One item is in work at a time.
// Reset clears the sequencer and the output valid and loads the modulus 2147483647.
// A finished result waits in the output register while the next item may be accepted.
`include "modular_field_alu_macros.svh"
module modular_field_alu (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfa_pkg::QW-1:0]         cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mfa_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // operand_a, operand_b
  input  logic [1:0]                     s_axis_tuser,   // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result, zero padding
  output logic                           m_axis_tuser    // no_inverse
);
  import mfa_pkg::*;

  logic [QW-1:0] modulus;
  logic          out_free;
  core_stat_t    stat;
  result_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = stat.idle;

  mfa_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (s_axis_tvalid && s_axis_tready),
    .op_in    (s_axis_tuser),
    .a_in     (s_axis_tdata[OPW-1:0]),
    .b_in     (s_axis_tdata[2*OPW-1:OPW]),
    .modulus  (modulus),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      m_axis_tdata <= OUT_TDATA_W'(res.value);
      m_axis_tuser <= res.no_inverse;
    end
  end

  `MFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `MFA_ASSERT_SAME(a_done_has_room, clk, rst, stat.done, !m_axis_tvalid || m_axis_tready)
  `MFA_ASSERT_SAME(a_flag_zero_result, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

endmodule
